// ===== hw/rtl/upd_pkg.sv =====
// shared types, character constants and helper functions for the url percent decoder
package upd_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_HEX1,
        MODE_HEX2,
        MODE_SKIP
    } mode_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       err;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } dec_out_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_value(input logic [7:0] b);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (b inside {[8'h30:8'h39]})
        begin
            d.value = 4'(b - 8'h30);
        end
        else if (b inside {[8'h41:8'h46]})
        begin
            d.value = 4'(b - 8'h37);
        end
        else if (b inside {[8'h61:8'h66]})
        begin
            d.value = 4'(b - 8'h57);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [7:0] to_space(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b == CH_PLUS || b == CH_CR || b == CH_LF)
        begin
            r = CH_SPACE;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/upd_decode.sv =====
// escape state machine and byte decode for one buffered input word
module upd_decode
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,   // buffered word is consumed this cycle
    input  logic [7:0]       in_byte,
    output upd_pkg::dec_out_t dec
);

    upd_pkg::mode_t     mode_reg;
    upd_pkg::mode_t     mode_next;
    logic [3:0]         high_nibble_reg;
    logic [3:0]         high_nibble_next;
    upd_pkg::hex_digit_t digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= upd_pkg::MODE_PLAIN;
            high_nibble_reg <= 4'd0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            high_nibble_reg <= high_nibble_next;
        end
    end

    always_comb
    begin
        digit            = upd_pkg::hex_value(in_byte);
        mode_next        = mode_reg;
        high_nibble_next = high_nibble_reg;
        dec.emit         = 1'b0;
        dec.res.data     = 8'd0;
        dec.res.eos      = 1'b0;
        dec.res.err      = 1'b0;

        case (mode_reg)
            upd_pkg::MODE_PLAIN:
            begin
                if (in_byte == upd_pkg::CH_NUL)
                begin
                    dec.emit    = 1'b1;
                    dec.res.eos = 1'b1;
                end
                else if (in_byte == upd_pkg::CH_PERCENT)
                begin
                    mode_next = upd_pkg::MODE_HEX1;
                end
                else
                begin
                    dec.emit     = 1'b1;
                    dec.res.data = upd_pkg::to_space(in_byte);
                end
            end
            upd_pkg::MODE_HEX1, upd_pkg::MODE_HEX2:
            begin
                if (in_byte == upd_pkg::CH_NUL)
                begin
                    // terminator inside an escape ends the string with an error
                    mode_next   = upd_pkg::MODE_PLAIN;
                    dec.emit    = 1'b1;
                    dec.res.eos = 1'b1;
                    dec.res.err = 1'b1;
                end
                else if (!digit.ok)
                begin
                    mode_next   = upd_pkg::MODE_SKIP;
                    dec.emit    = 1'b1;
                    dec.res.eos = 1'b1;
                    dec.res.err = 1'b1;
                end
                else if (mode_reg == upd_pkg::MODE_HEX1)
                begin
                    high_nibble_next = digit.value;
                    mode_next        = upd_pkg::MODE_HEX2;
                end
                else
                begin
                    mode_next    = upd_pkg::MODE_PLAIN;
                    dec.emit     = 1'b1;
                    dec.res.data = upd_pkg::to_space({high_nibble_reg, digit.value});
                end
            end
            upd_pkg::MODE_SKIP:
            begin
                // rest of a bad string is dropped silently
                if (in_byte == upd_pkg::CH_NUL)
                begin
                    mode_next = upd_pkg::MODE_PLAIN;
                end
            end
            default:
            begin
                mode_next = upd_pkg::MODE_PLAIN;
            end
        endcase
    end

endmodule

// ===== hw/rtl/url_percent_decoder.sv =====
// top level of the url percent decoder: input register, decode, output register
//
// Decodes a url-encoded byte stream, one encoded byte per input word.
// Slave side (s_*): one encoded byte per word; a zero byte ends the string.
// Master side (m_*): one decoded byte per word; m_tlast marks the end word of a
// string (data zero), m_tuser flags a malformed escape on that end word, and the
// consumer then discards the string. Escape bytes and dropped bytes give no word.
// Throughput: one input word per cycle, sustained while m_tready stays high, as
// the decode is a single shallow pass between the input register and the output
// register. An accepted word waits in the input register, is decoded and is loaded
// into the output register, which drives m_*; back-pressure can hold it in between.
// While m_tready is low, the output register holds its word and the input
// register still takes one more word; s_tready drops only when both are full.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// escape state to plain text.
module url_percent_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser     // [0] decode_error
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    upd_pkg::result_t   out_res_reg;
    upd_pkg::dec_out_t  dec;
    logic               out_free;
    logic               advance;
    logic               s_accept;

    upd_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_byte (in_byte_reg),
        .dec     (dec)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!dec.emit || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && dec.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && dec.emit)
        begin
            out_res_reg <= dec.res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.data;
    assign m_tlast  = out_res_reg.eos;
    assign m_tuser  = out_res_reg.err;

endmodule
